// File: rtl/core/uoe_pkg.sv
`default_nettype none

package uoe_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_V = 2;
  localparam int unsigned FLAG_N = 3;

  localparam logic [7:0] MAGIC_RST = 8'hFF;

  typedef enum logic [4:0] {
    OP_KIL = 5'd0,
    OP_LAX = 5'd1,
    OP_SAX = 5'd2,
    OP_DCP = 5'd3,
    OP_ISB = 5'd4,
    OP_SLO = 5'd5,
    OP_RLA = 5'd6,
    OP_SRE = 5'd7,
    OP_RRA = 5'd8,
    OP_ANC = 5'd9,
    OP_ALR = 5'd10,
    OP_ARR = 5'd11,
    OP_AXS = 5'd12,
    OP_XAA = 5'd13,
    OP_LAS = 5'd14,
    OP_SHA = 5'd15,
    OP_SHX = 5'd16,
    OP_SHY = 5'd17,
    OP_TAS = 5'd18,
    OP_ATX = 5'd19
  } uoe_op_t;

  typedef enum logic {
    REG_MAGIC = 1'b0,
    REG_DUMMY = 1'b1
  } uoe_reg_t;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [7:0]  reg_a;
    logic [7:0]  reg_x;
    logic [7:0]  reg_y;
    logic [7:0]  reg_sp;
    logic [3:0]  flags_in;
    logic [15:0] effective_address;
    logic [7:0]  operand_byte;
  } uoe_req_t;

  typedef struct packed {
    logic [7:0]  new_a;
    logic [7:0]  new_x;
    logic [7:0]  new_sp;
    logic [3:0]  flags_out;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        dummy_write_first;
    logic        may_add_cycle;
    logic        halt;
  } uoe_rsp_t;

  typedef struct packed {
    logic [7:0] magic;
    logic       dummy_en;
  } uoe_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/uoe_in_if.sv
`default_nettype none

interface uoe_in_if;
  logic               valid;
  logic               ready;
  uoe_pkg::uoe_req_t  word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

// File: rtl/core/uoe_out_if.sv
`default_nettype none

interface uoe_out_if;
  logic               valid;
  logic               ready;
  uoe_pkg::uoe_rsp_t  word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

// File: rtl/core/uoe_cfg_regs.sv
`default_nettype none

module uoe_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [uoe_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [uoe_pkg::CFG_DW-1:0]   pwdata,
  output logic      [uoe_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready,
  output uoe_pkg::uoe_cfg_t                 cfg
);
  import uoe_pkg::*;

  logic [7:0] magic_r, magic_nxt;
  logic       dummy_en_r, dummy_en_nxt;
  logic       wr_en;
  uoe_reg_t   sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = uoe_reg_t'(paddr[2]);

  always_comb begin
    magic_nxt    = magic_r;
    dummy_en_nxt = dummy_en_r;
    prdata       = '0;
    unique case (sel)
      REG_MAGIC: begin
        prdata = {{(CFG_DW-8){1'b0}}, magic_r};
        if (wr_en) begin
          magic_nxt = pwdata[7:0];
        end
      end
      REG_DUMMY: begin
        prdata = {{(CFG_DW-1){1'b0}}, dummy_en_r};
        if (wr_en) begin
          dummy_en_nxt = pwdata[0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= MAGIC_RST;
      dummy_en_r <= 1'b1;
    end else begin
      magic_r    <= magic_nxt;
      dummy_en_r <= dummy_en_nxt;
    end
  end

  assign cfg.magic    = magic_r;
  assign cfg.dummy_en = dummy_en_r;

endmodule

`default_nettype wire

// File: rtl/core/uoe_alu.sv
`default_nettype none

module uoe_alu (
  input  uoe_pkg::uoe_req_t req,
  input  uoe_pkg::uoe_cfg_t cfg,
  output uoe_pkg::uoe_rsp_t rsp
);
  import uoe_pkg::*;

  logic [7:0]  a, x, sp, m, t, idx, oth, hi, addend;
  logic [3:0]  f;
  logic [8:0]  sum;
  logic [15:0] ea, base;
  logic        rmw, do_add;

  always_comb begin
    a      = req.reg_a;
    x      = req.reg_x;
    sp     = req.reg_sp;
    f      = req.flags_in;
    m      = req.operand_byte;
    ea     = req.effective_address;
    t      = 8'h00;
    idx    = 8'h00;
    oth    = 8'h00;
    hi     = 8'h00;
    base   = 16'h0000;
    addend = 8'h00;
    sum    = 9'h000;
    rmw    = 1'b0;
    do_add = 1'b0;
    rsp    = '0;

    case (req.req_type)
      OP_KIL: rsp.halt = 1'b1;
      OP_LAX: begin
        a = m;
        x = m;
        rsp.may_add_cycle = 1'b1;
      end
      OP_SAX: begin
        rsp.write_enable  = 1'b1;
        rsp.write_address = ea;
        rsp.write_data    = a & x;
      end
      OP_DCP: begin
        t = m - 8'd1;
        rmw = 1'b1;
        f[FLAG_C] = (a >= t);
      end
      OP_ISB: begin
        t = m + 8'd1;
        rmw = 1'b1;
        addend = ~t;
        do_add = 1'b1;
      end
      OP_SLO: begin
        f[FLAG_C] = m[7];
        t = {m[6:0], 1'b0};
        rmw = 1'b1;
        a = a | t;
      end
      OP_RLA: begin
        t = {m[6:0], f[FLAG_C]};
        f[FLAG_C] = m[7];
        rmw = 1'b1;
        a = a & t;
      end
      OP_SRE: begin
        f[FLAG_C] = m[0];
        t = {1'b0, m[7:1]};
        rmw = 1'b1;
        a = a ^ t;
      end
      OP_RRA: begin
        t = {f[FLAG_C], m[7:1]};
        f[FLAG_C] = m[0];
        rmw = 1'b1;
        addend = t;
        do_add = 1'b1;
      end
      OP_ANC: begin
        a = a & m;
        f[FLAG_C] = a[7];
      end
      OP_ALR: begin
        t = a & m;
        f[FLAG_C] = t[0];
        a = {1'b0, t[7:1]};
      end
      OP_ARR: begin
        t = a & m;
        a = {f[FLAG_C], t[7:1]};
        f[FLAG_C] = a[6];
        f[FLAG_V] = a[6] ^ a[5];
      end
      OP_AXS: begin
        t = a & x;
        f[FLAG_C] = (t >= m);
        x = t - m;
      end
      OP_XAA: a = (a | cfg.magic) & x & m;
      OP_LAS: begin
        t = m & sp;
        a = t;
        x = t;
        sp = t;
        rsp.may_add_cycle = 1'b1;
      end
      OP_SHA: begin
        hi = ea[15:8] + 8'd1;
        rsp.write_enable  = 1'b1;
        rsp.write_address = ea;
        rsp.write_data    = a & x & hi;
      end
      OP_SHX, OP_SHY: begin
        if (req.req_type == OP_SHX) begin
          idx = x;
          oth = req.reg_y;
        end else begin
          idx = req.reg_y;
          oth = x;
        end
        base = ea - {8'h00, oth};
        hi   = base[15:8] + 8'd1;
        rsp.write_enable = 1'b1;
        rsp.write_data   = idx & hi;
        if (ea[15:8] != base[15:8]) begin
          rsp.write_address = {idx & hi, ea[7:0]};
        end else begin
          rsp.write_address = ea;
        end
      end
      OP_TAS: begin
        sp = a & x;
        hi = ea[15:8] + 8'd1;
        rsp.write_enable  = 1'b1;
        rsp.write_address = ea;
        rsp.write_data    = sp & hi;
      end
      OP_ATX: begin
        a = (a | cfg.magic) & m;
        x = a;
      end
      default: begin
        rsp.halt = 1'b0;
      end
    endcase

    if (do_add) begin
      sum = {1'b0, a} + {1'b0, addend} + {8'h00, f[FLAG_C]};
      f[FLAG_V] = (a[7] ^ sum[7]) & (addend[7] ^ sum[7]);
      f[FLAG_C] = sum[8];
      a = sum[7:0];
    end

    case (req.req_type)
      OP_LAX, OP_SLO, OP_RLA, OP_SRE, OP_ANC, OP_ALR, OP_ARR, OP_XAA, OP_ATX,
      OP_ISB, OP_RRA, OP_LAS: begin
        f[FLAG_Z] = (a == 8'h00);
        f[FLAG_N] = a[7];
      end
      OP_DCP: begin
        f[FLAG_Z] = (a == t);
        base[7:0] = a - t;
        f[FLAG_N] = base[7];
      end
      OP_AXS: begin
        f[FLAG_Z] = (x == 8'h00);
        f[FLAG_N] = x[7];
      end
      default: begin
        f = f;
      end
    endcase

    if (rmw) begin
      rsp.write_enable      = 1'b1;
      rsp.write_address     = ea;
      rsp.write_data        = t;
      rsp.dummy_write_first = cfg.dummy_en;
    end

    rsp.new_a     = a;
    rsp.new_x     = x;
    rsp.new_sp    = sp;
    rsp.flags_out = f;
  end

endmodule

`default_nettype wire

// File: rtl/core/undocumented_opcode_execute_core.sv
`default_nettype none

// Channel   Direction  Handshake       Payload
// in_ch     sink       valid/ready     uoe_req_t word: opcode, registers, flags, address, operand
// out_ch    source     valid/ready     uoe_rsp_t word: registers, flags, store, control bits
// psel...   APB slave  pready tied 1   magic constant at 0x0, dummy write enable at 0x4
//
// A word passes from input to output through the input register and then the result
// register, with the execute logic between them.
// One word is accepted every cycle while out_ch.ready is high.
// Reset clears both stage valid bits and loads the configuration reset values.
// When out_ch stalls, the input register still fills, so one extra word is taken.

module undocumented_opcode_execute_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  uoe_in_if.sink                           in_ch,
  uoe_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [uoe_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [uoe_pkg::CFG_DW-1:0]  pwdata,
  output logic      [uoe_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);
  import uoe_pkg::*;

  uoe_cfg_t cfg;
  uoe_rsp_t rsp;

  logic     s1_vld_r, s1_vld_nxt;
  uoe_req_t s1_req_r;
  logic     s2_vld_r, s2_vld_nxt;
  uoe_rsp_t s2_rsp_r;
  logic     s2_adv, s1_adv;

  uoe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  uoe_alu u_alu (
    .req (s1_req_r),
    .cfg (cfg),
    .rsp (rsp)
  );

  assign s2_adv      = !s2_vld_r || out_ch.ready;
  assign s1_adv      = !s1_vld_r || s2_adv;
  assign in_ch.ready = s1_adv;

  assign s1_vld_nxt = s1_adv ? in_ch.valid : s1_vld_r;
  assign s2_vld_nxt = s2_adv ? s1_vld_r : s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_req_r <= in_ch.word;
    end
    if (s2_adv && s1_vld_r) begin
      s2_rsp_r <= rsp;
    end
  end

  assign out_ch.valid = s2_vld_r;
  assign out_ch.word  = s2_rsp_r;

endmodule

`default_nettype wire

// File: tb/undocumented_opcode_execute_core_tb.sv
`default_nettype none

module undocumented_opcode_execute_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uoe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 250;
  localparam int unsigned RANDOM_PER_PHASE = 300;
  localparam logic [4:0] OP_NONE_LO = 5'd20;
  localparam logic [4:0] OP_NONE_HI = 5'd31;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  uoe_in_if in_ch ();
  uoe_out_if out_ch ();

  undocumented_opcode_execute_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  uoe_req_t pending_words[$];
  uoe_rsp_t expected_results[$];
  logic [7:0] magic_cfg;
  logic dummy_cfg;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  logic hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] set_nz(logic [3:0] f, logic [7:0] v);
    f[FLAG_Z] = (v == 8'h00);
    f[FLAG_N] = v[7];
    return f;
  endfunction

  function automatic logic [7:0] add_with_carry(logic [7:0] a, logic [7:0] m,
                                               inout logic [3:0] f);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, m} + {8'h00, f[FLAG_C]};
    f[FLAG_V] = (a[7] ^ s[7]) & (m[7] ^ s[7]);
    f[FLAG_C] = s[8];
    f = set_nz(f, s[7:0]);
    return s[7:0];
  endfunction

  function automatic uoe_rsp_t execute_opcode(uoe_req_t r);
    uoe_rsp_t rs;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] sp;
    logic [7:0] m;
    logic [7:0] t;
    logic [7:0] hi;
    logic [3:0] f;
    logic [15:0] ea;
    logic [15:0] base;
    logic rmw;
    a = r.reg_a;
    x = r.reg_x;
    sp = r.reg_sp;
    m = r.operand_byte;
    f = r.flags_in;
    ea = r.effective_address;
    rs = '0;
    rmw = 1'b0;
    case (r.req_type)
      OP_KIL: rs.halt = 1'b1;
      OP_LAX: begin
        a = m;
        x = m;
        f = set_nz(f, m);
        rs.may_add_cycle = 1'b1;
      end
      OP_SAX: begin
        rs.write_enable = 1'b1;
        rs.write_address = ea;
        rs.write_data = a & x;
      end
      OP_DCP: begin
        t = m - 8'd1;
        rmw = 1'b1;
        rs.write_data = t;
        f[FLAG_C] = (a >= t);
        f = set_nz(f, a - t);
      end
      OP_ISB: begin
        t = m + 8'd1;
        rmw = 1'b1;
        rs.write_data = t;
        a = add_with_carry(a, ~t, f);
      end
      OP_SLO: begin
        f[FLAG_C] = m[7];
        t = {m[6:0], 1'b0};
        rmw = 1'b1;
        rs.write_data = t;
        a = a | t;
        f = set_nz(f, a);
      end
      OP_RLA: begin
        t = {m[6:0], f[FLAG_C]};
        f[FLAG_C] = m[7];
        rmw = 1'b1;
        rs.write_data = t;
        a = a & t;
        f = set_nz(f, a);
      end
      OP_SRE: begin
        f[FLAG_C] = m[0];
        t = {1'b0, m[7:1]};
        rmw = 1'b1;
        rs.write_data = t;
        a = a ^ t;
        f = set_nz(f, a);
      end
      OP_RRA: begin
        t = {f[FLAG_C], m[7:1]};
        f[FLAG_C] = m[0];
        rmw = 1'b1;
        rs.write_data = t;
        a = add_with_carry(a, t, f);
      end
      OP_ANC: begin
        a = a & m;
        f = set_nz(f, a);
        f[FLAG_C] = a[7];
      end
      OP_ALR: begin
        t = a & m;
        f[FLAG_C] = t[0];
        a = {1'b0, t[7:1]};
        f = set_nz(f, a);
      end
      OP_ARR: begin
        t = a & m;
        a = {f[FLAG_C], t[7:1]};
        f = set_nz(f, a);
        f[FLAG_C] = a[6];
        f[FLAG_V] = a[6] ^ a[5];
      end
      OP_AXS: begin
        t = a & x;
        f[FLAG_C] = (t >= m);
        x = t - m;
        f = set_nz(f, x);
      end
      OP_XAA: begin
        a = (a | magic_cfg) & x & m;
        f = set_nz(f, a);
      end
      OP_LAS: begin
        t = m & sp;
        a = t;
        x = t;
        sp = t;
        f = set_nz(f, t);
        rs.may_add_cycle = 1'b1;
      end
      OP_SHA: begin
        hi = ea[15:8] + 8'd1;
        rs.write_enable = 1'b1;
        rs.write_address = ea;
        rs.write_data = a & x & hi;
      end
      OP_SHX, OP_SHY: begin
        base = ea - {8'h00, (r.req_type == OP_SHX) ? r.reg_y : x};
        hi = base[15:8] + 8'd1;
        rs.write_data = ((r.req_type == OP_SHX) ? x : r.reg_y) & hi;
        rs.write_address = ea;
        if (ea[15:8] != base[15:8]) begin
          rs.write_address = {rs.write_data, ea[7:0]};
        end
        rs.write_enable = 1'b1;
      end
      OP_TAS: begin
        sp = a & x;
        hi = ea[15:8] + 8'd1;
        rs.write_enable = 1'b1;
        rs.write_address = ea;
        rs.write_data = sp & hi;
      end
      OP_ATX: begin
        a = (a | magic_cfg) & m;
        x = a;
        f = set_nz(f, a);
      end
      default: ;
    endcase
    if (rmw) begin
      rs.write_enable = 1'b1;
      rs.write_address = ea;
      rs.dummy_write_first = dummy_cfg;
    end
    rs.new_a = a;
    rs.new_x = x;
    rs.new_sp = sp;
    rs.flags_out = f;
    return rs;
  endfunction

  function automatic uoe_req_t random_word();
    uoe_req_t r;
    if ($urandom_range(9) != 0) begin
      r.req_type = 5'($urandom_range(int'(OP_ATX)));
    end else begin
      r.req_type = 5'($urandom_range(int'(OP_NONE_HI), int'(OP_NONE_LO)));
    end
    r.reg_a = 8'($urandom);
    r.reg_x = 8'($urandom);
    r.reg_y = 8'($urandom);
    r.reg_sp = 8'($urandom);
    r.flags_in = 4'($urandom);
    r.effective_address = 16'($urandom);
    r.operand_byte = 8'($urandom);
    return r;
  endfunction

  task automatic note_mismatch(string what, uoe_rsp_t want, uoe_rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected %p", what, want);
      $display("%s: actual   %p", what, got);
    end
  endtask

  // Sender: a word stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(execute_opcode(in_ch.word));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.word <= pending_words.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected word", '0, out_ch.word);
        end else if (out_ch.word !== expected_results[0]) begin
          note_mismatch("result", expected_results.pop_front(), out_ch.word);
        end else begin
          void'(expected_results.pop_front());
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("undocumented_opcode_execute_core: mismatch");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic cfg_write(uoe_reg_t idx, logic [CFG_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MAGIC) begin
      magic_cfg = value[7:0];
    end else begin
      dummy_cfg = value[0];
    end
    @(posedge clk);
  endtask

  task automatic queue_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      pending_words.push_back(random_word());
    end
  endtask

  task automatic queue_directed();
    uoe_req_t r;
    for (int op = 0; op <= int'(OP_ATX); op++) begin
      r = (op % 2 == 1) ? '1 : '0;
      r.req_type = 5'(op);
      pending_words.push_back(r);
    end
    r = random_word();
    r.req_type = OP_NONE_LO;
    pending_words.push_back(r);
    r = '1;
    r.req_type = OP_NONE_HI;
    pending_words.push_back(r);
    // In the first word the index carries the address into the next page; in the second it does not.
    r = random_word();
    r.req_type = OP_SHX;
    r.effective_address = 16'h1005;
    r.reg_y = 8'h10;
    r.reg_x = 8'hF3;
    pending_words.push_back(r);
    r = random_word();
    r.req_type = OP_SHY;
    r.effective_address = 16'h12FF;
    r.reg_x = 8'h01;
    r.reg_y = 8'hA7;
    pending_words.push_back(r);
    // Signed overflow on the subtract.
    r = random_word();
    r.req_type = OP_ISB;
    r.reg_a = 8'h7F;
    r.operand_byte = 8'hFE;
    r.flags_in = 4'b0001;
    pending_words.push_back(r);
    r = '1;
    r.req_type = OP_ARR;
    pending_words.push_back(r);
  endtask

  initial begin
    logic [7:0] magic_set[5];
    logic dummy_set[5];
    int unsigned idle_tx[5];
    int unsigned idle_rx[5];
    magic_set = '{8'hFF, 8'h00, 8'h5A, 8'hFF, 8'h00};
    dummy_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    idle_tx = '{0, 62, 0, 17, 0};
    idle_rx = '{0, 0, 62, 17, 0};
    magic_set[4] = 8'($urandom);
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.word = '0;
    out_ch.ready = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    magic_cfg = MAGIC_RST;
    dummy_cfg = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        wait_drained();
        cfg_write(REG_MAGIC, {24'h0, magic_set[p]});
        cfg_write(REG_DUMMY, {31'h0, dummy_set[p]});
      end
      send_idle_pct = idle_tx[p];
      recv_stall_pct = idle_rx[p];
      if (p == 0) begin
        queue_directed();
        queue_random(RANDOM_PER_PHASE / 2);
        wait_drained();
        queue_random(RANDOM_PER_PHASE / 2);
      end else if (p == 4) begin
        // The receiver holds off while the sender keeps offering words.
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        queue_random(RANDOM_PER_PHASE);
      end else begin
        queue_random(RANDOM_PER_PHASE);
      end
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("undocumented_opcode_execute_core: match");
    end else begin
      $display("undocumented_opcode_execute_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/uoe_pkg.sv
rtl/core/uoe_in_if.sv
rtl/core/uoe_out_if.sv
rtl/core/uoe_cfg_regs.sv
rtl/core/uoe_alu.sv
rtl/core/undocumented_opcode_execute_core.sv
tb/undocumented_opcode_execute_core_tb.sv
